// ----- rtl/aging_page_replacement_defines.svh -----
// Assertion macros shared by the aging page replacement RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define APR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aging page replacement check failed");

// next-cycle implication
`define APR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aging page replacement check failed");

`endif

// ----- rtl/apr_pkg.sv -----
// Package for the aging page replacement block: FSM states, register indexes,
// reset values and the scan control struct. No dependencies.
package apr_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_MARK      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_PERIOD    = 2'd2;

    localparam int PERIOD_W         = 8;
    localparam int FIU_RESET        = 4;
    localparam int AGE_MARK_RESET   = 8;
    localparam int AGE_PERIOD_RESET = 1;
    localparam int FAULT_W          = 32;

    typedef struct packed {
        logic clear;      // start of a new pass
        logic ent_valid;  // an entry is presented this cycle
        logic in_active;  // entry lies among filled frames within the limit
        logic in_limit;   // entry lies within the frame limit
    } t_scan_ctl;

endpackage

// ----- rtl/apr_mem.sv -----
// Frame table memory: page number and age counter per frame.
// One write port, one read port, registered read data. No dependencies.
module apr_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/apr_scan.sv -----
// Scan unit: over one pass of the frame table, finds the first hit and the
// first frame with the least aged counter. Depends on apr_pkg.
module apr_scan
    import apr_pkg::*;
#(
    parameter int IW        = 6,
    parameter int PAGE_BITS = 20,
    parameter int AGE_BITS  = 10
) (
    input  logic                 i_clk,
    input  t_scan_ctl            i_ctl,
    input  logic [IW-1:0]        i_idx,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [AGE_BITS-1:0]  i_age,
    input  logic [PAGE_BITS-1:0] i_ref_page,
    output logic                 o_hit,
    output logic [IW-1:0]        o_hit_idx,
    output logic [AGE_BITS-1:0]  o_hit_age,
    output logic [IW-1:0]        o_min_idx,
    output logic [PAGE_BITS-1:0] o_min_page
);

    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    logic [AGE_BITS-1:0]  r_hit_age;
    logic                 r_min_seen;
    logic [IW-1:0]        r_min_idx;
    logic [AGE_BITS-1:0]  r_min_age;
    logic [PAGE_BITS-1:0] r_min_page;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_hit      <= 1'b0;
            r_min_seen <= 1'b0;
        end else if (i_ctl.ent_valid) begin
            if (i_ctl.in_active && !r_hit && (i_page == i_ref_page)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= i_idx;
                r_hit_age <= i_age;
            end
            if (i_ctl.in_limit && (!r_min_seen || (i_age < r_min_age))) begin
                r_min_seen <= 1'b1;
                r_min_idx  <= i_idx;
                r_min_age  <= i_age;
                r_min_page <= i_page;
            end
        end
    end

    assign o_hit      = r_hit;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_age  = r_hit_age;
    assign o_min_idx  = r_min_idx;
    assign o_min_page = r_min_page;

endmodule

// ----- rtl/aging_page_replacement.sv -----
// Aging page replacement. One reference in flight: a new page number is taken
// only in the idle state, so no new reference starts before the last one has
// finished its pass over the frame table through the single read port and its
// update. Synchronous active-low reset clears control, fill count, reference
// and fault counters and loads register defaults; the table is not cleared.
// Depends on apr_pkg, apr_mem, apr_scan and aging_page_replacement_defines.svh.
`include "aging_page_replacement_defines.svh"

module aging_page_replacement
    import apr_pkg::*;
#(
    parameter int FRAMES    = 64,
    parameter int PAGE_BITS = 20,
    parameter int AGE_BITS  = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [((($clog2(FRAMES)+1) > AGE_BITS) ?
                   ((($clog2(FRAMES)+1) > PERIOD_W) ? ($clog2(FRAMES)+1) : PERIOD_W) :
                   ((AGE_BITS > PERIOD_W) ? AGE_BITS : PERIOD_W))-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [PAGE_BITS-1:0]           i_page_number,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_hit,
    output logic                           o_replaced,
    output logic [$clog2(FRAMES)-1:0]      o_frame_index,
    output logic [PAGE_BITS-1:0]           o_evicted_page,
    output logic [FAULT_W-1:0]             o_fault_count
);

    localparam int IW = $clog2(FRAMES);
    localparam int FW = IW + 1;
    localparam int MW = PAGE_BITS + AGE_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

    t_state r_state, n_state;

    logic [FW-1:0]        r_frames_in_use;
    logic [AGE_BITS-1:0]  r_age_mark;
    logic [PERIOD_W-1:0]  r_age_period;

    logic [FW-1:0]        r_filled;
    logic [PERIOD_W-1:0]  r_ref;
    logic [FAULT_W-1:0]   r_fault;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_age_now;
    logic                 r_rd_on;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_pv;
    logic [IW-1:0]        r_pidx;

    logic                 r_out_valid;
    logic                 r_hit_o;
    logic                 r_repl_o;
    logic [IW-1:0]        r_frame_o;
    logic [PAGE_BITS-1:0] r_evict_o;
    logic [FAULT_W-1:0]   r_fault_o;

    logic [FW-1:0]        limit;
    logic [FW-1:0]        active;
    logic [PERIOD_W-1:0]  period_eff;
    logic [PERIOD_W:0]    ref_next;
    logic                 age_due;
    logic                 in_acc;
    logic                 upd_go;
    logic                 do_fill;

    logic                 mem_we;
    logic [IW-1:0]        mem_wr_addr;
    logic [MW-1:0]        mem_wr_data;
    logic [MW-1:0]        mem_rd_data;
    logic [PAGE_BITS-1:0] rd_page;
    logic [AGE_BITS-1:0]  rd_age;
    logic [AGE_BITS-1:0]  aged;

    t_scan_ctl            scan_ctl;
    logic                 scan_hit;
    logic [IW-1:0]        scan_hit_idx;
    logic [AGE_BITS-1:0]  scan_hit_age;
    logic [IW-1:0]        scan_min_idx;
    logic [PAGE_BITS-1:0] scan_min_page;

    // effective limit and period
    always_comb begin
        if (r_frames_in_use == '0) begin
            limit = FW'(1);
        end else if (r_frames_in_use > FW'(FRAMES)) begin
            limit = FW'(FRAMES);
        end else begin
            limit = r_frames_in_use;
        end
        active     = (r_filled < limit) ? r_filled : limit;
        period_eff = (r_age_period == '0) ? PERIOD_W'(1) : r_age_period;
        ref_next   = {1'b0, r_ref} + (PERIOD_W+1)'(1);
        age_due    = (ref_next >= {1'b0, period_eff});
    end

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign upd_go     = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign do_fill    = !scan_hit && (r_filled < limit);

    assign rd_page = mem_rd_data[MW-1:AGE_BITS];
    assign rd_age  = mem_rd_data[AGE_BITS-1:0];
    assign aged    = r_age_now ? (rd_age >> 1) : rd_age;

    always_comb begin
        scan_ctl.clear     = in_acc;
        scan_ctl.ent_valid = r_pv;
        scan_ctl.in_active = ({1'b0, r_pidx} < active);
        scan_ctl.in_limit  = ({1'b0, r_pidx} < limit);
    end

    // write port: aging write-back during the pass, final update after it
    always_comb begin
        mem_we      = 1'b0;
        mem_wr_addr = r_pidx;
        mem_wr_data = {rd_page, aged};
        if (upd_go) begin
            mem_we = 1'b1;
            if (scan_hit) begin
                mem_wr_addr = scan_hit_idx;
                mem_wr_data = {r_page, scan_hit_age | r_age_mark};
            end else if (do_fill) begin
                mem_wr_addr = r_filled[IW-1:0];
                mem_wr_data = {r_page, r_age_mark};
            end else begin
                mem_wr_addr = scan_min_idx;
                mem_wr_data = {r_page, r_age_mark};
            end
        end else if (r_pv && r_age_now) begin
            mem_we = 1'b1;
        end
    end

    apr_mem #(
        .DEPTH (FRAMES),
        .WIDTH (MW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (mem_rd_data)
    );

    apr_scan #(
        .IW        (IW),
        .PAGE_BITS (PAGE_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_idx      (r_pidx),
        .i_page     (rd_page),
        .i_age      (aged),
        .i_ref_page (r_page),
        .o_hit      (scan_hit),
        .o_hit_idx  (scan_hit_idx),
        .o_hit_age  (scan_hit_age),
        .o_min_idx  (scan_min_idx),
        .o_min_page (scan_min_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pv && (r_pidx == LAST_IDX)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FW'(FIU_RESET);
            r_age_mark      <= AGE_BITS'(AGE_MARK_RESET);
            r_age_period    <= PERIOD_W'(AGE_PERIOD_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAMES_IN_USE: r_frames_in_use <= i_cfg_data[FW-1:0];
                CFG_AGE_MARK:      r_age_mark      <= i_cfg_data[AGE_BITS-1:0];
                CFG_AGE_PERIOD:    r_age_period    <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_ref       <= '0;
            r_fault     <= '0;
            r_rd_on     <= 1'b0;
            r_rd_idx    <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= r_rd_on;
            if (in_acc) begin
                r_ref    <= age_due ? '0 : ref_next[PERIOD_W-1:0];
                r_rd_on  <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_rd_on) begin
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_on <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + IW'(1);
                end
            end
            if (upd_go) begin
                r_out_valid <= 1'b1;
                if (!scan_hit && do_fill) begin
                    r_filled <= r_filled + FW'(1);
                end else if (!scan_hit) begin
                    r_fault <= r_fault + FAULT_W'(1);
                end
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pidx <= r_rd_idx;
        if (in_acc) begin
            r_page    <= i_page_number;
            r_age_now <= age_due;
        end
        if (upd_go) begin
            r_hit_o  <= scan_hit;
            r_repl_o <= !scan_hit && !do_fill;
            if (scan_hit) begin
                r_frame_o <= scan_hit_idx;
                r_evict_o <= '0;
                r_fault_o <= r_fault;
            end else if (do_fill) begin
                r_frame_o <= r_filled[IW-1:0];
                r_evict_o <= '0;
                r_fault_o <= r_fault;
            end else begin
                r_frame_o <= scan_min_idx;
                r_evict_o <= scan_min_page;
                r_fault_o <= r_fault + FAULT_W'(1);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit_o;
    assign o_replaced     = r_repl_o;
    assign o_frame_index  = r_frame_o;
    assign o_evicted_page = r_evict_o;
    assign o_fault_count  = r_fault_o;

    `APR_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_filled <= FW'(FRAMES))
    `APR_ASSERT_IMP(a_hit_not_repl, i_clk, i_rst_n, r_out_valid, !(r_hit_o && r_repl_o))
    `APR_ASSERT_IMP(a_pipe_in_scan, i_clk, i_rst_n, r_pv, r_state == S_SCAN)
    `APR_ASSERT_NXT(a_acc_scan, i_clk, i_rst_n, in_acc, r_state == S_SCAN && r_rd_on)

endmodule
